// ===== design/ptc_pkg.sv =====
// shared types, constants and helpers for the pressure and temperature compensator
package ptc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM_1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM_2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM_3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_2_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_4_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_6_7 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_8_9 = 3'd7;

    localparam logic [15:0] RST_TEMP_TRIM_1    = 16'd27504;
    localparam logic [15:0] RST_TEMP_TRIM_2    = 16'd26435;
    localparam logic [15:0] RST_TEMP_TRIM_3    = 16'hFC18;
    localparam logic [15:0] RST_PRESS_TRIM_1   = 16'd36477;
    localparam logic [31:0] RST_PRESS_TRIM_2_3 = 32'd198235715;
    localparam logic [31:0] RST_PRESS_TRIM_4_5 = 32'd9177895;
    localparam logic [31:0] RST_PRESS_TRIM_6_7 = 32'd1015873529;
    localparam logic [31:0] RST_PRESS_TRIM_8_9 = 32'd393266936;

    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [11:0]        NUM_SCALE   = 12'd3125;
    localparam logic [63:0]        V1_BIAS     = 64'h0000_8000_0000_0000;
    localparam int unsigned        DIV_STEPS   = 64;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } trim_t;

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [19:0] adc_p;
    } temp_res_t;

    typedef struct packed {
        logic        [31:0] centi;
        logic        [31:0] fine;
        logic        [63:0] num;
        logic signed [30:0] den;
    } coef_res_t;

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic        nz;
        logic [63:0] quo;
    } div_res_t;

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [31:0] press;
        logic        pvalid;
    } ptc_res_t;

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx49_64(input logic [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

endpackage

// ===== design/ptc_temp.sv =====
// temperature path: five stages from raw reading to fine temperature and centidegrees
module ptc_temp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [19:0]          raw_temperature,
    input  logic [19:0]          raw_pressure,
    input  ptc_pkg::trim_t       trim,
    output logic                 out_valid,
    output ptc_pkg::temp_res_t   out_data
);

    logic [4:0]  v_reg;
    logic [19:0] adcp_reg [0:4];

    logic signed [17:0] adiff_reg, adiff_next;
    logic signed [16:0] d_reg, d_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] dsq_reg, dsq_next;
    logic [31:0] tv1_reg, tv1_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] fine4_reg, fine4_next;
    logic [31:0] fine5_reg;
    logic [31:0] centi_reg, centi_next;

    logic signed [33:0] prod_full;
    logic signed [33:0] dsq_full;
    logic signed [35:0] m_full;
    logic [31:0]        f5;

    always_comb
    begin
        adiff_next = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
        d_next     = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, trim.t1});
        prod_full  = adiff_reg * $signed(trim.t2);
        dsq_full   = d_reg * d_reg;
        prod_next  = prod_full[31:0];
        dsq_next   = dsq_full[31:0];
        tv1_next   = $signed(prod_reg) >>> 11;
        m_full     = $signed(dsq_reg[31:12]) * $signed(trim.t3);
        m_next     = m_full[31:0];
        fine4_next = tv1_reg + 32'($signed(m_reg) >>> 14);
        f5         = fine4_reg + {fine4_reg[29:0], 2'b00} + 32'd128;
        centi_next = $signed(f5) >>> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adcp_reg[0] <= raw_pressure;
            for (int k = 1; k < 5; k++)
            begin
                adcp_reg[k] <= adcp_reg[k-1];
            end
            adiff_reg <= adiff_next;
            d_reg     <= d_next;
            prod_reg  <= prod_next;
            dsq_reg   <= dsq_next;
            tv1_reg   <= tv1_next;
            m_reg     <= m_next;
            fine4_reg <= fine4_next;
            fine5_reg <= fine4_reg;
            centi_reg <= centi_next;
        end
    end

    assign out_valid      = v_reg[4];
    assign out_data.centi = centi_reg;
    assign out_data.fine  = fine5_reg;
    assign out_data.adc_p = adcp_reg[4];

endmodule

// ===== design/ptc_coef.sv =====
// pressure polynomial: eight stages giving the division numerator and divisor
module ptc_coef (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ptc_pkg::temp_res_t   in_data,
    input  ptc_pkg::trim_t       trim,
    output logic                 out_valid,
    output ptc_pkg::coef_res_t   out_data
);

    logic [7:0]         v_reg;
    ptc_pkg::temp_res_t side_reg [0:7];

    logic signed [32:0] v1_reg, v1_next;
    logic [63:0]        sq_reg, sq_next;
    logic signed [48:0] v1p5_reg [0:2];
    logic signed [48:0] v1p2_reg [0:2];
    logic signed [48:0] v1p5_next, v1p2_next;
    logic signed [48:0] p6lo_reg, p6lo_next, p3lo_reg, p3lo_next;
    logic [31:0]        p6hi_reg, p6hi_next, p3hi_reg, p3hi_next;
    logic [63:0]        sq6_reg, sq6_next, sq3_reg, sq3_next;
    logic [63:0]        v2_reg, v2_next, v1b_reg, v1b_next;
    logic [47:0]        plo_reg, plo_next;
    logic [31:0]        phi_reg, phi_next;
    logic [63:0]        na_reg, na_next;
    logic signed [30:0] den_reg, den_next, den8_reg;
    logic [43:0]        nlo_reg, nlo_next;
    logic [31:0]        nhi_reg, nhi_next;
    logic [63:0]        num_reg, num_next;

    logic signed [65:0] sq_full;
    logic [63:0]        prod1;
    logic [20:0]        pp;

    always_comb
    begin
        v1_next   = $signed({in_data.fine[31], in_data.fine}) - ptc_pkg::FINE_OFFSET;
        sq_full   = v1_reg * v1_reg;
        sq_next   = sq_full[63:0];
        v1p5_next = v1_reg * $signed(trim.p5);
        v1p2_next = v1_reg * $signed(trim.p2);
        p6lo_next = $signed({1'b0, sq_reg[31:0]}) * $signed(trim.p6);
        p3lo_next = $signed({1'b0, sq_reg[31:0]}) * $signed(trim.p3);
        p6hi_next = sq_reg[63:32] * ptc_pkg::sx16_32(trim.p6);
        p3hi_next = sq_reg[63:32] * ptc_pkg::sx16_32(trim.p3);
        sq6_next  = ptc_pkg::sx49_64(p6lo_reg) + {p6hi_reg, 32'd0};
        sq3_next  = ptc_pkg::sx49_64(p3lo_reg) + {p3hi_reg, 32'd0};
        v2_next   = sq6_reg + (ptc_pkg::sx49_64(v1p5_reg[2]) << 17)
                  + (ptc_pkg::sx16_64(trim.p4) << 35);
        v1b_next  = 64'($signed(sq3_reg) >>> 8) + (ptc_pkg::sx49_64(v1p2_reg[2]) << 12)
                  + ptc_pkg::V1_BIAS;
        plo_next  = v1b_reg[31:0] * trim.p1;
        phi_next  = v1b_reg[63:32] * {16'd0, trim.p1};
        pp        = ptc_pkg::PRESS_FULL - {1'b0, side_reg[4].adc_p};
        na_next   = {12'd0, pp, 31'd0} - v2_reg;
        prod1     = {16'd0, plo_reg} + {phi_reg, 32'd0};
        den_next  = $signed(prod1[63:33]);
        nlo_next  = na_reg[31:0] * ptc_pkg::NUM_SCALE;
        nhi_next  = na_reg[63:32] * {20'd0, ptc_pkg::NUM_SCALE};
        num_next  = {20'd0, nlo_reg} + {nhi_reg, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_data;
            for (int k = 1; k < 8; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            v1_reg      <= v1_next;
            sq_reg      <= sq_next;
            v1p5_reg[0] <= v1p5_next;
            v1p2_reg[0] <= v1p2_next;
            for (int k = 1; k < 3; k++)
            begin
                v1p5_reg[k] <= v1p5_reg[k-1];
                v1p2_reg[k] <= v1p2_reg[k-1];
            end
            p6lo_reg <= p6lo_next;
            p3lo_reg <= p3lo_next;
            p6hi_reg <= p6hi_next;
            p3hi_reg <= p3hi_next;
            sq6_reg  <= sq6_next;
            sq3_reg  <= sq3_next;
            v2_reg   <= v2_next;
            v1b_reg  <= v1b_next;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            na_reg   <= na_next;
            den_reg  <= den_next;
            nlo_reg  <= nlo_next;
            nhi_reg  <= nhi_next;
            num_reg  <= num_next;
            den8_reg <= den_reg;
        end
    end

    assign out_valid      = v_reg[7];
    assign out_data.centi = side_reg[7].centi;
    assign out_data.fine  = side_reg[7].fine;
    assign out_data.num   = num_reg;
    assign out_data.den   = den8_reg;

endmodule

// ===== design/ptc_div.sv =====
// signed 64-bit by 31-bit divider, one quotient bit per pipeline stage
module ptc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ptc_pkg::coef_res_t   in_data,
    output logic                 out_valid,
    output ptc_pkg::div_res_t    out_data
);

    localparam int unsigned N = ptc_pkg::DIV_STEPS;

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic        nz;
        logic        qneg;
    } side_t;

    logic [N+1:0] v_reg;
    side_t        side_reg [0:N+1];
    logic [30:0]  rem_reg  [0:N];
    logic [63:0]  quo_reg  [0:N];
    logic [30:0]  ud_reg   [0:N];
    logic [32:0]  diff_next [1:N];
    logic [63:0]  res_reg, res_next;
    side_t        side_next;
    logic [63:0]  un_next;
    logic [30:0]  ud_next;

    always_comb
    begin
        side_next.centi = in_data.centi;
        side_next.fine  = in_data.fine;
        side_next.nz    = (in_data.den != '0);
        side_next.qneg  = in_data.num[63] ^ in_data.den[30];
        un_next         = in_data.num[63] ? (64'd0 - in_data.num) : in_data.num;
        ud_next         = in_data.den[30] ? (31'd0 - in_data.den) : in_data.den;
        for (int k = 1; k <= N; k++)
        begin
            diff_next[k] = {1'b0, rem_reg[k-1], quo_reg[k-1][63]} - {2'b00, ud_reg[k-1]};
        end
        res_next = side_reg[N].qneg ? (64'd0 - quo_reg[N]) : quo_reg[N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= un_next;
            ud_reg[0]   <= ud_next;
            for (int k = 1; k <= N; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                ud_reg[k]   <= ud_reg[k-1];
                rem_reg[k]  <= diff_next[k][32] ? {rem_reg[k-1][29:0], quo_reg[k-1][63]}
                                                : diff_next[k][30:0];
                quo_reg[k]  <= {quo_reg[k-1][62:0], ~diff_next[k][32]};
            end
            side_reg[N+1] <= side_reg[N];
            res_reg       <= res_next;
        end
    end

    assign out_valid      = v_reg[N+1];
    assign out_data.centi = side_reg[N+1].centi;
    assign out_data.fine  = side_reg[N+1].fine;
    assign out_data.nz    = side_reg[N+1].nz;
    assign out_data.quo   = res_reg;

endmodule

// ===== design/ptc_post.sv =====
// pressure correction after the division: six stages to the q24.8 result
module ptc_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ptc_pkg::div_res_t    in_data,
    input  ptc_pkg::trim_t       trim,
    output logic                 out_valid,
    output ptc_pkg::ptc_res_t    out_data
);

    logic [5:0]         v_reg;
    ptc_pkg::div_res_t  side_reg [0:5];

    logic [63:0]        lolo_reg, lolo_next;
    logic [31:0]        cross_reg, cross_next;
    logic signed [48:0] w2lo_reg, w2lo_next;
    logic [31:0]        w2hi_reg, w2hi_next;
    logic [63:0]        qq_reg, qq_next;
    logic [63:0]        w2_reg, w2_next;
    logic signed [48:0] w1lo_reg, w1lo_next;
    logic [31:0]        w1hi_reg, w1hi_next;
    logic [63:0]        w2s_reg [0:1];
    logic [63:0]        w2s_next;
    logic [63:0]        w1s_reg, w1s_next;
    logic [39:0]        sum_reg, sum_next;
    logic [31:0]        press_reg, press_next;

    logic [63:0] qs;
    logic [63:0] w1_full;
    logic [31:0] p7_sh;

    always_comb
    begin
        qs         = $signed(in_data.quo) >>> 13;
        lolo_next  = qs[31:0] * qs[31:0];
        cross_next = qs[31:0] * qs[63:32];
        w2lo_next  = $signed({1'b0, in_data.quo[31:0]}) * $signed(trim.p8);
        w2hi_next  = in_data.quo[63:32] * ptc_pkg::sx16_32(trim.p8);
        qq_next    = lolo_reg + {cross_reg[30:0], 1'b0, 32'd0};
        w2_next    = ptc_pkg::sx49_64(w2lo_reg) + {w2hi_reg, 32'd0};
        w1lo_next  = $signed({1'b0, qq_reg[31:0]}) * $signed(trim.p9);
        w1hi_next  = qq_reg[63:32] * ptc_pkg::sx16_32(trim.p9);
        w2s_next   = $signed(w2_reg) >>> 19;
        w1_full    = ptc_pkg::sx49_64(w1lo_reg) + {w1hi_reg, 32'd0};
        w1s_next   = $signed(w1_full) >>> 25;
        sum_next   = side_reg[3].quo[39:0] + w1s_reg[39:0] + w2s_reg[1][39:0];
        p7_sh      = {{12{trim.p7[15]}}, trim.p7, 4'd0};
        press_next = side_reg[4].nz ? (sum_reg[39:8] + p7_sh) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_data;
            for (int k = 1; k < 6; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            lolo_reg   <= lolo_next;
            cross_reg  <= cross_next;
            w2lo_reg   <= w2lo_next;
            w2hi_reg   <= w2hi_next;
            qq_reg     <= qq_next;
            w2_reg     <= w2_next;
            w1lo_reg   <= w1lo_next;
            w1hi_reg   <= w1hi_next;
            w2s_reg[0] <= w2s_next;
            w2s_reg[1] <= w2s_reg[0];
            w1s_reg    <= w1s_next;
            sum_reg    <= sum_next;
            press_reg  <= press_next;
        end
    end

    assign out_valid       = v_reg[5];
    assign out_data.centi  = side_reg[5].centi;
    assign out_data.fine   = side_reg[5].fine;
    assign out_data.press  = press_reg;
    assign out_data.pvalid = side_reg[5].nz;

endmodule

// ===== design/pressure_temperature_compensator_top.sv =====
// top level: trim registers, compensation pipeline and output skid stage
// throughput: one beat per cycle while the skid stage is empty, set by the fully
// pipelined datapath and the 64-stage bit-per-stage divider
// reset: trim registers load their calibration defaults, pipeline empties
module pressure_temperature_compensator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // temperature_centi, fine_temperature, pressure_q24_8
    output logic [0:0]  m_axis_tuser,   // pressure_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] temp_trim_1_reg, temp_trim_2_reg, temp_trim_3_reg, press_trim_1_reg;
    logic [31:0] press_trim_2_3_reg, press_trim_4_5_reg;
    logic [31:0] press_trim_6_7_reg, press_trim_8_9_reg;

    ptc_pkg::trim_t     trim;
    logic               pipe_en;
    logic               temp_v, coef_v, div_v, post_v;
    ptc_pkg::temp_res_t temp_d;
    ptc_pkg::coef_res_t coef_d;
    ptc_pkg::div_res_t  div_d;
    ptc_pkg::ptc_res_t  post_d;

    ptc_pkg::ptc_res_t  out_reg, skid_reg;
    logic               out_v_reg, skid_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_1_reg    <= ptc_pkg::RST_TEMP_TRIM_1;
            temp_trim_2_reg    <= ptc_pkg::RST_TEMP_TRIM_2;
            temp_trim_3_reg    <= ptc_pkg::RST_TEMP_TRIM_3;
            press_trim_1_reg   <= ptc_pkg::RST_PRESS_TRIM_1;
            press_trim_2_3_reg <= ptc_pkg::RST_PRESS_TRIM_2_3;
            press_trim_4_5_reg <= ptc_pkg::RST_PRESS_TRIM_4_5;
            press_trim_6_7_reg <= ptc_pkg::RST_PRESS_TRIM_6_7;
            press_trim_8_9_reg <= ptc_pkg::RST_PRESS_TRIM_8_9;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_TRIM_1:    temp_trim_1_reg    <= cfg_data[15:0];
                ptc_pkg::REG_TEMP_TRIM_2:    temp_trim_2_reg    <= cfg_data[15:0];
                ptc_pkg::REG_TEMP_TRIM_3:    temp_trim_3_reg    <= cfg_data[15:0];
                ptc_pkg::REG_PRESS_TRIM_1:   press_trim_1_reg   <= cfg_data[15:0];
                ptc_pkg::REG_PRESS_TRIM_2_3: press_trim_2_3_reg <= cfg_data;
                ptc_pkg::REG_PRESS_TRIM_4_5: press_trim_4_5_reg <= cfg_data;
                ptc_pkg::REG_PRESS_TRIM_6_7: press_trim_6_7_reg <= cfg_data;
                ptc_pkg::REG_PRESS_TRIM_8_9: press_trim_8_9_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        trim.t1 = temp_trim_1_reg;
        trim.t2 = temp_trim_2_reg;
        trim.t3 = temp_trim_3_reg;
        trim.p1 = press_trim_1_reg;
        trim.p2 = press_trim_2_3_reg[15:0];
        trim.p3 = press_trim_2_3_reg[31:16];
        trim.p4 = press_trim_4_5_reg[15:0];
        trim.p5 = press_trim_4_5_reg[31:16];
        trim.p6 = press_trim_6_7_reg[15:0];
        trim.p7 = press_trim_6_7_reg[31:16];
        trim.p8 = press_trim_8_9_reg[15:0];
        trim.p9 = press_trim_8_9_reg[31:16];
    end

    // pipeline holds only while the skid stage is occupied
    assign pipe_en       = ~skid_v_reg;
    assign s_axis_tready = pipe_en;

    ptc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (pipe_en),
        .in_valid        (s_axis_tvalid),
        .raw_temperature (s_axis_tdata[19:0]),
        .raw_pressure    (s_axis_tdata[39:20]),
        .trim            (trim),
        .out_valid       (temp_v),
        .out_data        (temp_d)
    );

    ptc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (temp_v),
        .in_data   (temp_d),
        .trim      (trim),
        .out_valid (coef_v),
        .out_data  (coef_d)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (coef_v),
        .in_data   (coef_d),
        .out_valid (div_v),
        .out_data  (div_d)
    );

    ptc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (div_v),
        .in_data   (div_d),
        .trim      (trim),
        .out_valid (post_v),
        .out_data  (post_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (post_v)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (post_v)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_reg <= post_d;
            end
            else
            begin
                skid_reg <= post_d;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_reg.press, out_reg.fine, out_reg.centi};
    assign m_axis_tuser  = out_reg.pvalid;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage full while output register empty");

    a_spill_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (post_v && pipe_en && out_v_reg && !m_axis_tready) |=> skid_v_reg)
        else $error("pipeline beat not caught by skid stage");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[95:64] == 32'd0))
        else $error("pressure not cleared for zero divisor");
`endif

endmodule

// ===== test/tb_checker.sv =====
// checker: watches the stream and config channels, predicts results and compares
`timescale 1ns / 1ps
module tb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    ptc_pkg::trim_t    trims;
    ptc_pkg::ptc_res_t expected_q[$];

    function automatic ptc_pkg::ptc_res_t compensate(input ptc_pkg::trim_t tr,
                                                     input logic [19:0] adc_t,
                                                     input logic [19:0] adc_p);
        logic signed [31:0] t1, t2, t3, a, tv1, d, tv2, fine;
        logic signed [63:0] v1, v2, p, q, w1, w2, num, f64;
        ptc_pkg::ptc_res_t r;
        t1 = {16'd0, tr.t1};
        t2 = tr.t2;
        t3 = tr.t3;
        a = ($signed({12'd0, adc_t >> 3}) - (t1 <<< 1)) * t2;
        tv1 = a >>> 11;
        d = $signed({12'd0, adc_t >> 4}) - t1;
        tv2 = (((d * d) >>> 12) * t3) >>> 14;
        fine = tv1 + tv2;
        r.fine = fine;
        r.centi = (fine * 5 + 128) >>> 8;
        f64 = fine;
        v1 = f64 - 64'sd128000;
        v2 = v1 * v1 * 64'(tr.p6);
        v2 = v2 + ((v1 * 64'(tr.p5)) <<< 17);
        v2 = v2 + (64'(tr.p4) <<< 35);
        v1 = ((v1 * v1 * 64'(tr.p3)) >>> 8) + ((v1 * 64'(tr.p2)) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * $signed({48'd0, tr.p1})) >>> 33;
        if (v1 == 0)
        begin
            r.press = 0;
            r.pvalid = 0;
        end
        else
        begin
            p = 64'sd1048576 - $signed({44'd0, adc_p});
            num = ((p <<< 31) - v2) * 64'sd3125;
            if (num == 64'h8000_0000_0000_0000 && v1 == -64'sd1)
                p = num;
            else
                p = num / v1;
            q = p >>> 13;
            w1 = (64'(tr.p9) * q * q) >>> 25;
            w2 = (64'(tr.p8) * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (64'(tr.p7) <<< 4);
            r.press = p[31:0];
            r.pvalid = 1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ptc_pkg::ptc_res_t want, got;
        if (!rst_n)
        begin
            trims <= '{ptc_pkg::RST_TEMP_TRIM_1, ptc_pkg::RST_TEMP_TRIM_2,
                       ptc_pkg::RST_TEMP_TRIM_3, ptc_pkg::RST_PRESS_TRIM_1,
                       ptc_pkg::RST_PRESS_TRIM_2_3[15:0], ptc_pkg::RST_PRESS_TRIM_2_3[31:16],
                       ptc_pkg::RST_PRESS_TRIM_4_5[15:0], ptc_pkg::RST_PRESS_TRIM_4_5[31:16],
                       ptc_pkg::RST_PRESS_TRIM_6_7[15:0], ptc_pkg::RST_PRESS_TRIM_6_7[31:16],
                       ptc_pkg::RST_PRESS_TRIM_8_9[15:0], ptc_pkg::RST_PRESS_TRIM_8_9[31:16]};
            fail_count <= 0;
            pending    <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ptc_pkg::REG_TEMP_TRIM_1:    trims.t1 <= cfg_data[15:0];
                    ptc_pkg::REG_TEMP_TRIM_2:    trims.t2 <= cfg_data[15:0];
                    ptc_pkg::REG_TEMP_TRIM_3:    trims.t3 <= cfg_data[15:0];
                    ptc_pkg::REG_PRESS_TRIM_1:   trims.p1 <= cfg_data[15:0];
                    ptc_pkg::REG_PRESS_TRIM_2_3: {trims.p3, trims.p2} <= cfg_data;
                    ptc_pkg::REG_PRESS_TRIM_4_5: {trims.p5, trims.p4} <= cfg_data;
                    ptc_pkg::REG_PRESS_TRIM_6_7: {trims.p7, trims.p6} <= cfg_data;
                    ptc_pkg::REG_PRESS_TRIM_8_9: {trims.p9, trims.p8} <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(compensate(trims, s_axis_tdata[19:0],
                                                s_axis_tdata[39:20]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tuser[0]};
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: centi %h/%h fine %h/%h press %h/%h valid %b/%b",
                                     want.centi, got.centi, want.fine, got.fine,
                                     want.press, got.press, want.pvalid, got.pvalid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top: clock, reset, stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_top;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    pressure_temperature_compensator_top dut (.*);

    tb_checker checker_i (.*);

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high after an accepted beat unless the next beat idles first
    task automatic send_beat(input logic [19:0] raw_t, input logic [19:0] raw_p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {raw_p, raw_t};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_trim(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // every trim register gets all zeros, all ones, max or min signed halves, or random data by mode
    task automatic load_trims(input int mode);
        logic [31:0] v;
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: v = '0;
                1: v = '1;
                2: v = 32'h7FFF_7FFF;
                3: v = 32'h8000_8000;
                default: v = $urandom();
            endcase
            write_trim(i[2:0], v);
        end
    endtask

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
        begin
            case (i / (count / 4 + 1))
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            send_beat($urandom(), $urandom());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_beat('0, '0);
        send_beat('1, '1);
        send_beat('0, '1);
        send_beat('1, '0);
        send_beat(20'd519888, 20'd415148);
        send_beat(20'hAAAAA, 20'h55555);
        send_beat(20'h55555, 20'hAAAAA);
        drain();
        for (int m = 0; m < 4; m++)
        begin
            load_trims(m);
            send_beat('0, '0);
            send_beat('1, '1);
            send_beat(20'h80000, 20'h7FFFF);
            random_items(20);
            drain();
        end
        write_trim(ptc_pkg::REG_TEMP_TRIM_1, 32'd27504);
        write_trim(ptc_pkg::REG_TEMP_TRIM_2, 32'd26435);
        write_trim(ptc_pkg::REG_TEMP_TRIM_3, 32'hFFFF_FC18);
        write_trim(ptc_pkg::REG_PRESS_TRIM_1, 32'd36477);
        write_trim(ptc_pkg::REG_PRESS_TRIM_2_3, ptc_pkg::RST_PRESS_TRIM_2_3);
        write_trim(ptc_pkg::REG_PRESS_TRIM_4_5, ptc_pkg::RST_PRESS_TRIM_4_5);
        write_trim(ptc_pkg::REG_PRESS_TRIM_6_7, ptc_pkg::RST_PRESS_TRIM_6_7);
        write_trim(ptc_pkg::REG_PRESS_TRIM_8_9, ptc_pkg::RST_PRESS_TRIM_8_9);
        random_items(800);
        drain();
        for (int k = 0; k < 3; k++)
        begin
            load_trims(4);
            random_items(280);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== pressure_temperature_compensator_top.f =====
design/ptc_pkg.sv
design/ptc_temp.sv
design/ptc_coef.sv
design/ptc_div.sv
design/ptc_post.sv
design/pressure_temperature_compensator_top.sv
test/tb_checker.sv
test/tb_top.sv
